FILE: design/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
package mts_pkg;

  localparam int WORD_W   = 32;
  localparam int DEPTH_W  = 9;
  localparam int STATUS_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic  opcode;
    word_t value;
  } req_t;

  typedef struct packed {
    word_t               popped_value;
    word_t               top_value;
    word_t               min_value;
    logic [DEPTH_W-1:0]  depth;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Shift command broadcast along a row of cells
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

FILE: design/min_tracking_stack_top.sv
// Min-tracking stack: shifting cell rows for entries and minima, one response per request.
// The response is registered and valid in the cycle after the request is accepted.
// One request per cycle unless an unread response stalls req_ready; both rows shift in
// the accept cycle, so each row's two top cells are always at hand for the next request.
// Reset (synchronous, active high) clears both counts and the response valid;
// cell contents are not cleared and need no clearing pass.
module min_tracking_stack_top #(
  parameter int STACK_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mts_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mts_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] main_count;
  logic [CNT_W-1:0] min_count;
  logic [CNT_W-1:0] main_count_next;
  logic [CNT_W-1:0] min_count_next;

  mts_pkg::word_t main_top0, main_top1;
  mts_pkg::word_t min_top0, min_top1;

  mts_pkg::shift_ctrl_t main_ctrl;
  mts_pkg::shift_ctrl_t min_ctrl;

  mts_pkg::rsp_t rsp_next;

  logic accept;
  logic is_push;
  logic main_empty;
  logic main_full;
  logic to_min;
  logic pop_min;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_push   = (req.opcode == mts_pkg::OP_PUSH);
  assign main_empty = (main_count == '0);
  assign main_full  = (main_count == CNT_W'(STACK_DEPTH));

  // Minimum row takes a push on empty stack, empty min row, or value <= min top
  assign to_min  = main_empty || (min_count == '0) || (req.value <= min_top0);
  assign pop_min = (min_count != '0) && (min_top0 == main_top0);

  // Operation decode and response assembly
  always_comb begin
    main_ctrl       = '0;
    min_ctrl        = '0;
    main_count_next = main_count;
    min_count_next  = min_count;
    rsp_next        = '0;
    rsp_next.status = mts_pkg::ST_OK;

    if (is_push) begin
      if (main_full) begin
        rsp_next.status = mts_pkg::ST_OVERFLOW;
      end else begin
        main_ctrl.push  = 1'b1;
        main_count_next = main_count + 1'b1;
        min_count_next  = main_empty ? '0 : min_count;
        if (to_min) begin
          min_ctrl.push  = 1'b1;
          min_count_next = min_count_next + 1'b1;
        end
      end
    end else begin
      if (main_empty) begin
        rsp_next.status = mts_pkg::ST_UNDERFLOW;
      end else begin
        main_ctrl.pop         = 1'b1;
        main_count_next       = main_count - 1'b1;
        rsp_next.popped_value = main_top0;
        if (pop_min) begin
          min_ctrl.pop   = 1'b1;
          min_count_next = min_count - 1'b1;
        end
      end
    end

    // Top and minimum after the operation
    if (main_count_next != '0) begin
      if (main_ctrl.push) begin
        rsp_next.top_value = req.value;
      end else if (main_ctrl.pop) begin
        rsp_next.top_value = main_top1;
      end else begin
        rsp_next.top_value = main_top0;
      end
      if (min_count_next != '0) begin
        if (min_ctrl.push) begin
          rsp_next.min_value = req.value;
        end else if (min_ctrl.pop) begin
          rsp_next.min_value = min_top1;
        end else begin
          rsp_next.min_value = min_top0;
        end
      end
    end

    rsp_next.depth    = mts_pkg::DEPTH_W'(main_count_next);
    rsp_next.is_empty = (main_count_next == '0);

    if (!accept) begin
      main_ctrl       = '0;
      min_ctrl        = '0;
      main_count_next = main_count;
      min_count_next  = min_count;
    end
  end

  // Counts and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      main_count <= '0;
      min_count  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      main_count <= main_count_next;
      min_count  <= min_count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Entry row
  mts_chain #(
    .DEPTH (STACK_DEPTH)
  ) u_main_chain (
    .clk        (clk),
    .ctrl       (main_ctrl),
    .push_value (req.value),
    .top0       (main_top0),
    .top1       (main_top1)
  );

  // Minimum row
  mts_chain #(
    .DEPTH (STACK_DEPTH)
  ) u_min_chain (
    .clk        (clk),
    .ctrl       (min_ctrl),
    .push_value (req.value),
    .top0       (min_top0),
    .top1       (min_top1)
  );

endmodule

FILE: design/mts_cell.sv
// One stack cell: holds a word, takes its upper neighbor on push, lower on pop.
module mts_cell (
  input  logic                clk,
  input  mts_pkg::shift_ctrl_t ctrl,
  input  mts_pkg::word_t      upper,
  input  mts_pkg::word_t      lower,
  output mts_pkg::word_t      data
);

  // Entry storage, no reset (contents undefined until written)
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      data <= upper;
    end else if (ctrl.pop) begin
      data <= lower;
    end
  end

endmodule

FILE: design/mts_chain.sv
// Row of stack cells; cell 0 is the top of the stack.
module mts_chain #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  mts_pkg::shift_ctrl_t ctrl,
  input  mts_pkg::word_t       push_value,
  output mts_pkg::word_t       top0,
  output mts_pkg::word_t       top1
);

  mts_pkg::word_t cell_data [DEPTH];

  // Each cell links to its neighbors; the ends take the new value or hold
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mts_pkg::word_t upper;
    mts_pkg::word_t lower;

    if (i == 0) begin : g_first
      assign upper = push_value;
    end else begin : g_mid_up
      assign upper = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign lower = cell_data[i];
    end else begin : g_mid_dn
      assign lower = cell_data[i+1];
    end

    mts_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .upper (upper),
      .lower (lower),
      .data  (cell_data[i])
    );
  end

  assign top0 = cell_data[0];
  assign top1 = cell_data[1];

endmodule
